// ----- rtl/core/dbtu_pkg.sv -----
// Package for the depth buffer test/update block: field widths, operation,
// status, register and state codes. No dependencies.
`timescale 1ns / 1ps

package dbtu_pkg;

    localparam int OPCODE_W   = 2;
    localparam int COORD_W    = 12;
    localparam int IO_DEPTH_W = 24;
    localparam int STATUS_W   = 2;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int DIM_W      = 13;   // holds any frame dimension up to 4096

    typedef enum logic [OPCODE_W-1:0] {
        OP_TEST  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_FARTHER = 2'd0,
        STS_DONE    = 2'd1,
        STS_EQUAL   = 2'd2,
        STS_OOB     = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'd0,
        CFG_FRAME_HEIGHT = 1'd1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOK,
        ST_CMP,
        ST_DONE,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
    } frame_cfg_t;

endpackage

// ----- rtl/core/dbtu_if.sv -----
// Valid/ready channel interfaces: fragment items in, result items out.
// Depends on dbtu_pkg.
`timescale 1ns / 1ps

interface dbtu_in_if;
    import dbtu_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OPCODE_W-1:0]       opcode;
    logic signed [COORD_W-1:0] col;
    logic signed [COORD_W-1:0] row;
    logic [IO_DEPTH_W-1:0]     depth;

    modport source (output valid, opcode, col, row, depth, input ready);
    modport sink   (input valid, opcode, col, row, depth, output ready);
endinterface

interface dbtu_out_if;
    import dbtu_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [IO_DEPTH_W-1:0] stored_depth;

    modport source (output valid, status, stored_depth, input ready);
    modport sink   (input valid, status, stored_depth, output ready);
endinterface

// ----- rtl/core/dbtu_ram.sv -----
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module dbtu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

// ----- rtl/core/dbtu_ctrl.sv -----
// Sequencer for the depth store: bounds check, read-modify-write, clearing
// sweep and output register. Depends on dbtu_pkg and dbtu_if.
`timescale 1ns / 1ps

module dbtu_ctrl #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int DEPTH_BITS = 24,
    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dbtu_pkg::frame_cfg_t  frame_cfg,
    dbtu_in_if.sink               frag,
    dbtu_out_if.source            result,
    output logic                  mem_en,
    output logic                  mem_we,
    output logic [AW-1:0]         mem_addr,
    output logic [DEPTH_BITS-1:0] mem_wdata,
    input  logic [DEPTH_BITS-1:0] mem_rdata
);
    import dbtu_pkg::*;

    localparam logic [DEPTH_BITS-1:0] FAR   = {DEPTH_BITS{1'b1}};
    localparam logic [AW-1:0]         PITCH = AW'(MAX_WIDTH);
    localparam logic [AW-1:0]         LAST  = AW'(STORE_SIZE - 1);
    localparam logic [DIM_W-1:0]      MAX_W = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0]      MAX_H = DIM_W'(MAX_HEIGHT);

    state_t                state_reg, state_next;
    logic [AW-1:0]         cnt_reg, cnt_next;
    logic [AW-1:0]         addr_reg, addr_next;
    op_t                   op_reg, op_next;
    logic [DEPTH_BITS-1:0] zv_reg, zv_next;
    status_t               res_status_reg, res_status_next;
    logic [DEPTH_BITS-1:0] res_depth_reg, res_depth_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [IO_DEPTH_W-1:0] out_depth_reg, out_depth_next;

    logic [DIM_W-1:0]      w_act, h_act;
    logic                  in_bounds;
    logic [AW-1:0]         frag_addr;
    logic                  accept;

    // Active size is the register clamped to the store size.
    assign w_act = (DIM_W'(frame_cfg.width) > MAX_W) ? MAX_W : DIM_W'(frame_cfg.width);
    assign h_act = (DIM_W'(frame_cfg.height) > MAX_H) ? MAX_H : DIM_W'(frame_cfg.height);

    assign in_bounds = !frag.col[COORD_W-1] && !frag.row[COORD_W-1]
                    && (DIM_W'(frag.col[COORD_W-2:0]) < w_act)
                    && (DIM_W'(frag.row[COORD_W-2:0]) < h_act);

    // Fixed pitch of MAX_WIDTH; only meaningful when in bounds.
    assign frag_addr = AW'(frag.row[COORD_W-2:0]) * PITCH + AW'(frag.col[COORD_W-2:0]);

    assign frag.ready          = (state_reg == ST_IDLE);
    assign accept              = frag.valid && frag.ready;
    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.stored_depth = out_depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        op_reg         <= op_next;
        zv_reg         <= zv_next;
        res_status_reg <= res_status_next;
        res_depth_reg  <= res_depth_next;
        out_status_reg <= out_status_next;
        out_depth_reg  <= out_depth_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        addr_next       = addr_reg;
        op_next         = op_reg;
        zv_next         = zv_reg;
        res_status_next = res_status_reg;
        res_depth_next  = res_depth_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_status_next = out_status_reg;
        out_depth_next  = out_depth_reg;
        mem_en          = 1'b0;
        mem_we          = 1'b0;
        mem_addr        = addr_reg;
        mem_wdata       = zv_reg;

        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                // One entry per cycle set to far.
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = cnt_reg;
                mem_wdata = FAR;
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == LAST)
                begin
                    cnt_next        = '0;
                    res_status_next = STS_DONE;
                    res_depth_next  = FAR;
                    state_next      = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = op_t'(frag.opcode);
                    addr_next = frag_addr;
                    zv_next   = DEPTH_BITS'(frag.depth);
                    if (op_t'(frag.opcode) == OP_CLEAR)
                    begin
                        cnt_next   = '0;
                        state_next = ST_CLEAR;
                    end
                    else if (!in_bounds)
                    begin
                        res_status_next = STS_OOB;
                        res_depth_next  = FAR;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK:
            begin
                mem_en     = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                // Read data is valid; write back in the same cycle if needed.
                res_status_next = STS_DONE;
                res_depth_next  = mem_rdata;
                unique case (op_reg)
                    OP_TEST:
                    begin
                        if (zv_reg < mem_rdata)
                        begin
                            mem_en         = 1'b1;
                            mem_we         = 1'b1;
                            res_depth_next = zv_reg;
                        end
                        else if (zv_reg > mem_rdata)
                        begin
                            res_status_next = STS_FARTHER;
                        end
                        else
                        begin
                            res_status_next = STS_EQUAL;
                        end
                    end
                    OP_WRITE:
                    begin
                        mem_en         = 1'b1;
                        mem_we         = 1'b1;
                        res_depth_next = zv_reg;
                    end
                    OP_READ, OP_CLEAR:
                    begin
                    end
                endcase
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_depth_next  = IO_DEPTH_W'(res_depth_reg);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/depth_buffer_test_update.sv -----
// Depth buffer test/update: fragment depth test, write, read and clear on a
// MAX_WIDTH x MAX_HEIGHT store in one synchronous RAM.
// In-bounds test/write/read items pass LOOK (RAM read), CMP (compare, write back), DONE;
// out-of-bounds items go straight to DONE; a clear sweeps every entry to far, then DONE.
// Items are taken only in IDLE, so one at a time: the single RAM port reads, then writes back.
// Reset: a sweep over all MAX_WIDTH*MAX_HEIGHT entries sets each to far; no item taken meanwhile.
`timescale 1ns / 1ps

module depth_buffer_test_update #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int DEPTH_BITS = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [dbtu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dbtu_pkg::CFG_W-1:0] cfg_data,
    dbtu_in_if.sink                    frag,
    dbtu_out_if.source                 result
);
    import dbtu_pkg::*;

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

    // Frame size registers; store contents are untouched by a change.
    frame_cfg_t frame_cfg_reg, frame_cfg_next;

    logic                  mem_en;
    logic                  mem_we;
    logic [AW-1:0]         mem_addr;
    logic [DEPTH_BITS-1:0] mem_wdata;
    logic [DEPTH_BITS-1:0] mem_rdata;

    always_comb
    begin
        frame_cfg_next = frame_cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FRAME_WIDTH:  frame_cfg_next.width  = cfg_data;
                CFG_FRAME_HEIGHT: frame_cfg_next.height = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_cfg_reg.width  <= CFG_W'(512);
            frame_cfg_reg.height <= CFG_W'(512);
        end
        else
        begin
            frame_cfg_reg <= frame_cfg_next;
        end
    end

    // Sequencer: bounds, read-modify-write, clearing sweep, output register.
    dbtu_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame_cfg (frame_cfg_reg),
        .frag      (frag),
        .result    (result),
        .mem_en    (mem_en),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    // Depth store, entry (col,row) at row*MAX_WIDTH+col.
    dbtu_ram #(
        .WIDTH (DEPTH_BITS),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for depth_buffer_test_update: directed and random fragment
// items against a behavioral depth store, with random stalls on both channels.
// Depends on dbtu_pkg, dbtu_if.sv and the block itself.
`timescale 1ns / 1ps

module tb;
    import dbtu_pkg::*;

    // Block sizing, kept at the defaults so a clear sweeps all MAX_W * MAX_H entries.
    localparam int MAX_W = 512;
    localparam int MAX_H = 512;
    localparam int DEPTH_BITS = 24;

    localparam logic [IO_DEPTH_W-1:0] FAR_Z = {IO_DEPTH_W{1'b1}};

    // Each side idles in about this many cycles out of a hundred.
    localparam int IDLE_PCT = 14;
    // Receiver hold-off used to back the block up into its input.
    localparam int LONG_HOLD = 150;
    // Allow a wide margin over the reset sweep plus two clears.
    localparam longint LIMIT_CYCLES = 3_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    bit steady;        // no idling on either side while set
    bit hold_request;  // asks the result side for one long hold-off

    dbtu_in_if  frag_ch ();
    dbtu_out_if res_ch ();

    depth_buffer_test_update #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H),
        .DEPTH_BITS (DEPTH_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frag      (frag_ch),
        .result    (res_ch)
    );

    typedef struct {
        status_t               status;
        logic [IO_DEPTH_W-1:0] depth;
    } depth_result_t;

    // Shadow of the depth store plus the queue of results still owed by the block.
    // Entries never written read as far, so a clear just empties the map.
    class depth_tracker;
        logic [IO_DEPTH_W-1:0] depth_shadow [int];
        depth_result_t         due[$];
        int                    frame_w = 512;
        int                    frame_h = 512;
        int                    errors = 0;

        function void note_fragment(op_t op, logic signed [COORD_W-1:0] col,
                                    logic signed [COORD_W-1:0] row,
                                    logic [IO_DEPTH_W-1:0] z);
            depth_result_t         exp_r;
            int                    c;
            int                    r;
            int                    lim_w;
            int                    lim_h;
            int                    idx;
            logic [IO_DEPTH_W-1:0] cur;
            c = col;
            r = row;
            lim_w = (frame_w > MAX_W) ? MAX_W : frame_w;
            lim_h = (frame_h > MAX_H) ? MAX_H : frame_h;
            exp_r.status = STS_OOB;
            exp_r.depth = FAR_Z;
            if (op == OP_CLEAR)
            begin
                depth_shadow.delete();
                exp_r.status = STS_DONE;
            end
            else if (c >= 0 && r >= 0 && c < lim_w && r < lim_h)
            begin
                // fixed pitch: row stride is the maximum width, not the active one
                idx = r * MAX_W + c;
                cur = depth_shadow.exists(idx) ? depth_shadow[idx] : FAR_Z;
                exp_r.status = STS_DONE;
                if (op == OP_TEST)
                begin
                    // smaller is closer
                    if (z > cur)
                        exp_r.status = STS_FARTHER;
                    else if (z == cur)
                        exp_r.status = STS_EQUAL;
                    else
                        cur = z;
                end
                else if (op == OP_WRITE)
                    cur = z;
                depth_shadow[idx] = cur;
                exp_r.depth = cur;
            end
            due.push_back(exp_r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [IO_DEPTH_W-1:0] d);
            depth_result_t exp_r;
            if (due.size() == 0)
            begin
                $error("unexpected result item: status %0d stored_depth %h", st, d);
                errors++;
                return;
            end
            exp_r = due.pop_front();
            if (st !== exp_r.status)
            begin
                $error("status: expected %0d, got %0d", exp_r.status, st);
                errors++;
            end
            if (d !== exp_r.depth)
            begin
                $error("stored_depth: expected %h, got %h", exp_r.depth, d);
                errors++;
            end
        endfunction

        function void close();
            if (due.size() != 0)
            begin
                $error("%0d result items never arrived", due.size());
                errors++;
            end
        endfunction
    endclass

    depth_tracker book;

    // Clock: 4 ns period.
    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driving tasks. Inputs move on the falling edge; handshakes are
    // sampled on the rising edge.
    // ------------------------------------------------------------------

    // Offer one item, idling at random first; returns at the accepting edge
    // with valid still high so back-to-back items never toggle it.
    task automatic send_fragment(op_t op, int col, int row, logic [IO_DEPTH_W-1:0] z);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            frag_ch.valid <= 1'b0;
            @(negedge clk);
        end
        frag_ch.valid  <= 1'b1;
        frag_ch.opcode <= op;
        frag_ch.col    <= COORD_W'(col);
        frag_ch.row    <= COORD_W'(row);
        frag_ch.depth  <= z;
        @(posedge clk);
        while (frag_ch.ready !== 1'b1)
            @(posedge clk);
        book.note_fragment(op_t'(frag_ch.opcode), frag_ch.col, frag_ch.row, frag_ch.depth);
    endtask

    // Drop valid after the last accepted item.
    task automatic park();
        @(negedge clk);
        frag_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (book.due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Registers change only with the block idle and nothing owed.
    task automatic set_frame(int w, int h);
        park();
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, CFG_W'(w));
        write_reg(CFG_FRAME_HEIGHT, CFG_W'(h));
        book.frame_w = w;
        book.frame_h = h;
    endtask

    // Coordinate picker: mostly a tiny hot corner so the same pixels get
    // hit again and again (equal / farther / closer), some spread over the
    // register range, some right at the bound, some anywhere in 12 bits.
    function automatic int pick_coord(int raw, int cap);
        int lim;
        int roll;
        int v;
        lim = (raw > cap) ? cap : raw;
        roll = $urandom_range(99);
        if (roll < 12)
            v = int'($urandom);
        else if (roll < 25 || lim == 0)
            v = lim - 2 + int'($urandom_range(3));
        else if (roll < 45)
            v = int'($urandom_range(raw - 1));
        else
            v = int'($urandom_range(((lim < 6) ? lim : 6) - 1));
        return v;
    endfunction

    // Depth picker: extremes, a tight cluster so equal compares happen, and
    // full 24-bit noise.
    function automatic logic [IO_DEPTH_W-1:0] pick_depth();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        if (roll < 16)
            return FAR_Z;
        if (roll < 45)
            return IO_DEPTH_W'(32'h003F_FFFF + $urandom_range(2));
        return IO_DEPTH_W'($urandom);
    endfunction

    // One random phase at the current frame size. hold_at starts the long
    // receiver hold-off, clear_at inserts the one random clear, pause_at
    // stops the sender until every owed result has come back (-1: none).
    task automatic run_random(int count, int hold_at, int clear_at, int pause_at);
        int  i;
        int  roll;
        op_t op;
        for (i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_request = 1'b1;
            if (i == pause_at)
            begin
                park();
                wait_drained();
            end
            roll = $urandom_range(99);
            op = (roll < 40) ? OP_TEST : (roll < 60) ? OP_WRITE : OP_READ;
            if (i == clear_at)
                op = OP_CLEAR;
            send_fragment(op, pick_coord(book.frame_w, MAX_W),
                          pick_coord(book.frame_h, MAX_H), pick_depth());
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready, one long hold-off on request, checks each
    // accepted result item against the oldest expectation.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                book.check_result(res_ch.status, res_ch.stored_depth);
        end
    end

    // Watchdog: covers the reset sweep, clears and stalls many times over.
    initial
    begin : watchdog
        longint cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        book = new();
        steady = 1'b0;
        hold_request = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_FRAME_WIDTH;
        cfg_data = '0;
        frag_ch.valid = 1'b0;
        frag_ch.opcode = OP_READ;
        frag_ch.col = '0;
        frag_ch.row = '0;
        frag_ch.depth = '0;
        res_ch.ready = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset frame size (512 x 512). The block is
        // still sweeping the store after reset; the handshake holds us off.
        send_fragment(OP_READ,  0, 0, 24'h000000);     // untouched pixel reads far
        send_fragment(OP_TEST,  0, 0, 24'h800000);     // closer than far: stored
        send_fragment(OP_TEST,  0, 0, 24'h800000);     // equal: ignored
        send_fragment(OP_TEST,  0, 0, 24'hFFFFFF);     // farther: ignored
        send_fragment(OP_TEST,  0, 0, 24'h000000);     // near plane wins
        send_fragment(OP_READ,  0, 0, 24'hABCDEF);
        send_fragment(OP_WRITE, 0, 0, 24'hFFFFFF);     // write back to far
        send_fragment(OP_TEST,  511, 511, 24'h123456); // last pixel of the frame
        send_fragment(OP_READ,  511, 511, 24'h000000);
        send_fragment(OP_TEST,  512, 0, 24'h000001);   // one past the right edge
        send_fragment(OP_TEST,  0, 512, 24'h000001);   // one past the bottom
        send_fragment(OP_WRITE, -1, 5, 24'h000002);    // negative column
        send_fragment(OP_WRITE, 5, -1, 24'h000002);    // negative row
        send_fragment(OP_READ,  -2048, -2048, 24'h000000);
        send_fragment(OP_READ,  2047, 2047, 24'hFFFFFF);
        send_fragment(OP_WRITE, 511, 0, 24'hAAAAAA);
        send_fragment(OP_WRITE, 0, 511, 24'h555555);
        send_fragment(OP_TEST,  511, 0, 24'hAAAAAA);
        // clear ignores col/row/depth, even nonsense ones
        send_fragment(OP_CLEAR, 1000, -5, 24'h123456);
        send_fragment(OP_READ,  511, 511, 24'h000000);
        send_fragment(OP_READ,  511, 0, 24'h000000);
        send_fragment(OP_TEST,  0, 511, 24'h000001);

        // Small frame, hot pixels; receiver backs off long enough to fill
        // the block while the sender keeps offering.
        set_frame(16, 8);
        run_random(160, 40, -1, -1);

        // Registers above the maximum: bound clips to 512, store kept.
        set_frame(1023, 1023);
        run_random(150, -1, -1, -1);

        // Zero width: everything out of bounds.
        set_frame(0, 512);
        run_random(40, -1, -1, -1);

        // Single pixel.
        set_frame(1, 1);
        run_random(60, -1, -1, -1);

        // Zero height.
        set_frame(512, 0);
        run_random(30, -1, -1, -1);

        // Random size with no idling on either side.
        set_frame(int'($urandom_range(1, 1023)), int'($urandom_range(1, 1023)));
        steady = 1'b1;
        run_random(150, -1, -1, -1);
        steady = 1'b0;

        // Height just over the maximum, one clear mid-phase, then a full
        // sender pause until the block has caught up.
        set_frame(20, 513);
        run_random(110, -1, 55, 80);

        park();
        wait_drained();
        repeat (16) @(posedge clk);
        book.close();

        if (book.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/dbtu_pkg.sv
rtl/core/dbtu_if.sv
rtl/core/dbtu_ram.sv
rtl/core/dbtu_ctrl.sv
rtl/core/depth_buffer_test_update.sv
bench/tb.sv
